// ----- src/i2cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types, codes and phase tables for the bit-level I2C master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

    localparam int unsigned PHASE_TICKS_W     = 8;
    localparam logic [7:0]  PHASE_TICKS_RESET = 8'd5;
    localparam int unsigned IDX_W             = 5;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_WACK  = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_SCL    = 2'd0,
        KIND_SDA    = 2'd1,
        KIND_SAMPLE = 2'd2
    } kind_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [1:0]       sub;
        logic             shift_msb;
        logic             ack_to_send;
    } phase_req_t;

    typedef struct packed {
        kind_t kind;
        logic  level;
    } phase_act_t;

    function automatic logic [IDX_W:0] phase_total(input op_t op);
        logic [IDX_W:0] tot;
        unique case (op)
            OP_START: tot = 6'd4;
            OP_STOP:  tot = 6'd3;
            OP_SEND:  tot = 6'd24;
            OP_WACK:  tot = 6'd4;
            OP_READ:  tot = 6'd28;
            default:  tot = 6'd0;
        endcase
        return tot;
    endfunction

endpackage

`default_nettype wire

// ----- src/i2cbm_phase.sv -----
// ----------------------------------------------------------------------------
// i2cbm_phase
// Decodes a command and phase position into the line action of that phase.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_phase
    import i2cbm_pkg::*;
(
    input  var phase_req_t req,
    output var phase_act_t act
);

    always_comb begin
        act.kind  = KIND_SCL;
        act.level = 1'b1;
        unique case (req.op)
            OP_START: begin
                unique case (req.idx)
                    5'd0:    begin act.kind = KIND_SDA; act.level = 1'b1; end
                    5'd1:    begin act.kind = KIND_SCL; act.level = 1'b1; end
                    5'd2:    begin act.kind = KIND_SDA; act.level = 1'b0; end
                    default: begin act.kind = KIND_SCL; act.level = 1'b0; end
                endcase
            end
            OP_STOP: begin
                unique case (req.idx)
                    5'd0:    begin act.kind = KIND_SDA; act.level = 1'b0; end
                    5'd1:    begin act.kind = KIND_SCL; act.level = 1'b1; end
                    default: begin act.kind = KIND_SDA; act.level = 1'b1; end
                endcase
            end
            OP_SEND: begin
                unique case (req.sub)
                    2'd0:    begin act.kind = KIND_SDA; act.level = req.shift_msb; end
                    2'd1:    begin act.kind = KIND_SCL; act.level = 1'b1; end
                    default: begin act.kind = KIND_SCL; act.level = 1'b0; end
                endcase
            end
            OP_WACK: begin
                unique case (req.idx)
                    5'd0:    begin act.kind = KIND_SDA;    act.level = 1'b1; end
                    5'd1:    begin act.kind = KIND_SCL;    act.level = 1'b1; end
                    5'd2:    begin act.kind = KIND_SAMPLE; act.level = 1'b1; end
                    default: begin act.kind = KIND_SCL;    act.level = 1'b0; end
                endcase
            end
            OP_READ: begin
                if (req.idx == 5'd0) begin
                    act.kind  = KIND_SDA;
                    act.level = 1'b1;
                end else if (req.idx <= 5'd24) begin
                    unique case (req.sub)
                        2'd1:    begin act.kind = KIND_SCL;    act.level = 1'b1; end
                        2'd2:    begin act.kind = KIND_SAMPLE; act.level = 1'b1; end
                        default: begin act.kind = KIND_SCL;    act.level = 1'b0; end
                    endcase
                end else if (req.idx == 5'd25) begin
                    act.kind  = KIND_SDA;
                    act.level = ~req.ack_to_send;
                end else begin
                    act.kind  = KIND_SCL;
                    act.level = (req.idx == 5'd26);
                end
            end
            default: begin
                act.kind  = KIND_SCL;
                act.level = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/i2c_bit_level_master_core.sv -----
// The result of an item is registered and presented on the m_ side in the cycle after it is accepted.
// Throughput: one item per cycle unless a result waits; the phase state updates in one pass.
// The output register frees itself when taken, so s_tready only drops while a result waits.
// Reset: synchronous, active low; lines released, sequence idle, phase_ticks to default 5.
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core
// Open-drain I2C master that steps SCL and SDA through the phases of a command.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master_core
    import i2cbm_pkg::*;
#(
    parameter logic [7:0] PHASE_TICKS_INIT = PHASE_TICKS_RESET
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [7:0] cfg_data,
    input  wire        s_tvalid,
    output logic       s_tready,
    // action[2:0], data_byte[10:3], send_ack[11], sda_level[12], zero[15:13]
    input  wire [15:0] s_tdata,
    output logic       m_tvalid,
    input  wire        m_tready,
    // scl_level[0], sda_drive[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_bit[12], rejected[13], zero[15:14]
    output logic [15:0] m_tdata
);

    logic [7:0]       phase_ticks_reg;
    op_t              op_reg, op_next, op_pre;
    logic [IDX_W-1:0] idx_reg, idx_next, idx_pre;
    logic [1:0]       sub_reg, sub_next, sub_pre;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       shift_reg, shift_next, shift_pre;
    logic             ats_reg, ats_next, ats_pre;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic [7:0]       rbyte_reg, rbyte_next;
    logic             ack_reg, ack_next;
    logic             done_next, rej_next, do_phase;
    logic             mvalid_reg;
    logic [15:0]      mdata_reg;

    logic [2:0] in_action;
    logic [7:0] in_data;
    logic       in_send_ack, in_sda;
    logic       accept, is_cmd;
    logic [7:0] tick_inc, limit;
    logic [IDX_W:0] idx_inc;

    phase_req_t req;
    phase_act_t act;

    assign in_action   = s_tdata[2:0];
    assign in_data     = s_tdata[10:3];
    assign in_send_ack = s_tdata[11];
    assign in_sda      = s_tdata[12];

    assign cfg_ready = 1'b1;
    assign s_tready  = ~mvalid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign is_cmd    = (in_action >= 3'(OP_START)) && (in_action <= 3'(OP_READ));
    assign tick_inc  = tick_reg + 8'd1;
    assign limit     = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign idx_inc   = {1'b0, idx_reg} + 6'd1;

    i2cbm_phase u_phase (
        .req (req),
        .act (act)
    );

    always_comb begin
        op_pre    = op_reg;
        idx_pre   = idx_reg;
        sub_pre   = sub_reg;
        shift_pre = shift_reg;
        ats_pre   = ats_reg;
        tick_next = tick_reg;
        rbyte_next = rbyte_reg;
        done_next = 1'b0;
        rej_next  = 1'b0;
        do_phase  = 1'b0;
        if (is_cmd) begin
            if (op_reg != OP_IDLE) begin
                rej_next = 1'b1;
            end else begin
                op_pre    = op_t'(in_action);
                idx_pre   = '0;
                sub_pre   = 2'd0;
                ats_pre   = in_send_ack;
                shift_pre = (in_action == 3'(OP_SEND)) ? in_data : 8'd0;
                do_phase  = 1'b1;
            end
        end else if (op_reg != OP_IDLE) begin
            tick_next = tick_inc;
            if (tick_inc >= limit) begin
                if (idx_inc >= phase_total(op_reg)) begin
                    if (op_reg == OP_READ) begin
                        rbyte_next = shift_reg;
                    end
                    op_pre    = OP_IDLE;
                    idx_pre   = '0;
                    sub_pre   = 2'd0;
                    tick_next = 8'd0;
                    done_next = 1'b1;
                end else begin
                    idx_pre  = idx_inc[IDX_W-1:0];
                    sub_pre  = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                    do_phase = 1'b1;
                end
            end
        end
    end

    always_comb begin
        req.op          = op_pre;
        req.idx         = idx_pre;
        req.sub         = sub_pre;
        req.shift_msb   = shift_pre[7];
        req.ack_to_send = ats_pre;
    end

    always_comb begin
        op_next    = op_pre;
        idx_next   = idx_pre;
        sub_next   = sub_pre;
        ats_next   = ats_pre;
        shift_next = shift_pre;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        if (do_phase) begin
            unique case (act.kind)
                KIND_SCL: scl_next = act.level;
                KIND_SDA: begin
                    sda_next = act.level;
                    if (op_pre == OP_SEND) begin
                        shift_next = {shift_pre[6:0], 1'b0};
                    end
                end
                default: begin
                    if (op_pre == OP_WACK) begin
                        ack_next = in_sda;
                    end else begin
                        shift_next = {shift_pre[6:0], in_sda};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_INIT;
            op_reg     <= OP_IDLE;
            idx_reg    <= '0;
            sub_reg    <= 2'd0;
            tick_reg   <= 8'd0;
            shift_reg  <= 8'd0;
            ats_reg    <= 1'b0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            rbyte_reg  <= 8'd0;
            ack_reg    <= 1'b1;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                phase_ticks_reg <= cfg_data;
            end
            if (accept) begin
                op_reg    <= op_next;
                idx_reg   <= idx_next;
                sub_reg   <= sub_next;
                tick_reg  <= do_phase ? 8'd0 : tick_next;
                shift_reg <= shift_next;
                ats_reg   <= ats_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                rbyte_reg <= rbyte_next;
                ack_reg   <= ack_next;
            end
            if (accept) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mdata_reg <= {2'b00, rej_next, ack_next, rbyte_next, done_next,
                          (op_next != OP_IDLE), sda_next, scl_next};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

`ifndef SYNTH
    a_busy_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg != OP_IDLE) |-> ({1'b0, idx_reg} < phase_total(op_reg)))
        else $error("phase index beyond the end of the running command");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[13]) |-> m_tdata[2])
        else $error("command rejected while idle");

    a_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (sub_reg != 2'd3))
        else $error("phase sub-counter out of range");
`endif

endmodule

`default_nettype wire
